>>> src/pc2sn_pkg.sv
package pc2sn_pkg;

    // Path byte codes that steer the parser.
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_SEP  = 8'h2F;
    localparam logic [7:0] CH_BSEP = 8'h5C;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    // Space-padded empty name fields.
    localparam logic [63:0] SPACES_BASE = 64'h2020_2020_2020_2020;
    localparam logic [23:0] SPACES_EXT  = 24'h20_2020;

    // Longest legal base and extension, and the saturation point of the length count.
    localparam logic [3:0] BASE_MAX = 4'd8;
    localparam logic [3:0] EXT_MAX  = 4'd3;
    localparam logic [3:0] LEN_SAT  = 4'd15;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_BASE  = 3'd0,
        PH_EXT   = 3'd1,
        PH_DRAIN = 3'd2
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DIR      = 3'd0,
        ST_FILE     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BASE_ERR = 3'd3,
        ST_EXT_ERR  = 3'd4
    } status_t;

    // One result beat.
    typedef struct packed {
        status_t      status;
        logic [63:0]  base_name;
        logic [23:0]  extension;
    } res_t;

endpackage

>>> src/pc2sn_in_reg.sv
module pc2sn_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       take,
    output logic       q_valid,
    output logic [7:0] q_ch
);
    import pc2sn_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] ch_reg;

    // The register accepts a new beat when empty or when its beat is consumed.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid || (valid_reg && !take);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= ch;
        end
    end

    assign q_valid = valid_reg;
    assign q_ch    = ch_reg;

    // A held beat that is not consumed stays held.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg)
        else $error("input register lost a beat");

endmodule

>>> src/pc2sn_parse.sv
module pc2sn_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       ch,
    input  logic             go,
    output logic             res_valid,
    output pc2sn_pkg::res_t  res
);
    import pc2sn_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [63:0] base_reg;
    logic [63:0] base_next;
    logic [23:0] ext_reg;
    logic [23:0] ext_next;
    logic [3:0]  len_reg;
    logic [3:0]  len_next;
    logic        skip_reg;
    logic        skip_next;

    logic is_nul;
    logic is_sep;
    logic is_dot;
    logic is_name;

    // Byte classes.
    always_comb
    begin
        is_nul  = (ch == CH_NUL);
        is_sep  = ch inside {CH_SEP, CH_BSEP};
        is_dot  = (ch == CH_DOT);
        is_name = !(is_nul || is_sep || is_dot);
    end

    // Next state and result for one path byte.
    always_comb
    begin
        phase_next    = phase_reg;
        base_next     = base_reg;
        ext_next      = ext_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        res_valid     = 1'b0;
        res.status    = ST_DIR;
        res.base_name = '0;
        res.extension = '0;

        case (phase_reg)
            PH_BASE:
            begin
                if (skip_reg && is_sep)
                begin
                    skip_next = 1'b0;
                end
                else if (skip_reg && is_nul)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_EMPTY;
                end
                else
                begin
                    skip_next = 1'b0;
                    if (is_name)
                    begin
                        // Store the byte while the base has room.
                        if (!len_reg[3])
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                if (len_reg[2:0] == 3'(i))
                                begin
                                    base_next[8*(7-i) +: 8] = ch;
                                end
                            end
                        end
                        if (len_reg != LEN_SAT)
                        begin
                            len_next = len_reg + 4'd1;
                        end
                    end
                    else if (len_reg > BASE_MAX)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_BASE_ERR;
                        if (!is_nul)
                        begin
                            phase_next = PH_DRAIN;
                        end
                    end
                    else if (is_dot)
                    begin
                        phase_next = PH_EXT;
                        len_next   = '0;
                    end
                    else
                    begin
                        res_valid     = 1'b1;
                        res.status    = is_nul ? ST_FILE : ST_DIR;
                        res.base_name = base_reg;
                        res.extension = ext_reg;
                    end
                end
            end
            PH_EXT:
            begin
                if (is_name)
                begin
                    // Store the byte while the extension has room.
                    if (len_reg < EXT_MAX)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if (len_reg[1:0] == 2'(i))
                            begin
                                ext_next[8*(2-i) +: 8] = ch;
                            end
                        end
                    end
                    if (len_reg != LEN_SAT)
                    begin
                        len_next = len_reg + 4'd1;
                    end
                end
                else if (len_reg > EXT_MAX)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_EXT_ERR;
                    if (!is_nul)
                    begin
                        phase_next = PH_DRAIN;
                    end
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.status    = is_nul ? ST_FILE : ST_DIR;
                    res.base_name = base_reg;
                    res.extension = ext_reg;
                end
            end
            default:
            begin
                // Draining: wait for the end of the path.
            end
        endcase

        // A delimiter that ends a good component starts the next one.
        if (res_valid && (res.status == ST_DIR))
        begin
            base_next  = SPACES_BASE;
            ext_next   = SPACES_EXT;
            len_next   = '0;
            skip_next  = 1'b0;
            phase_next = is_dot ? PH_EXT : PH_BASE;
        end

        // Every NUL returns the parser to the start of a path.
        if (is_nul)
        begin
            base_next  = SPACES_BASE;
            ext_next   = SPACES_EXT;
            len_next   = '0;
            skip_next  = 1'b1;
            phase_next = PH_BASE;
        end
    end

    // State registers advance only when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BASE;
            base_reg  <= SPACES_BASE;
            ext_reg   <= SPACES_EXT;
            len_reg   <= '0;
            skip_reg  <= 1'b1;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            ext_reg   <= ext_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
        end
    end

    // The start-of-path flag is only ever set with a fresh, empty base.
    a_skip_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (phase_reg == PH_BASE) && (len_reg == 4'd0))
        else $error("skip flag set outside a fresh path");

    // An empty path is only reported at the start of a path.
    a_empty_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == ST_EMPTY) |-> skip_reg)
        else $error("empty path reported mid-path");

    // A consumed NUL always leaves the parser at path start.
    a_nul_restart: assert property (@(posedge clk) disable iff (!rst_n)
        go && is_nul |=> skip_reg && (phase_reg == PH_BASE))
        else $error("NUL did not restart the path");

endmodule

>>> src/pc2sn_out_reg.sv
module pc2sn_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             res_valid,
    input  pc2sn_pkg::res_t  res,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       status,
    output logic [63:0]      base_name,
    output logic [23:0]      extension
);
    import pc2sn_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // A new result may enter when the register is empty or its beat leaves now.
    assign room       = !valid_reg || out_ready;
    assign valid_next = (load && res_valid) || (valid_reg && !out_ready);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign status    = res_reg.status;
    assign base_name = res_reg.base_name;
    assign extension = res_reg.extension;

    // Error and empty results carry no name.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !(res_reg.status == ST_DIR || res_reg.status == ST_FILE)
        |-> (res_reg.base_name == 64'd0) && (res_reg.extension == 24'd0))
        else $error("error result carries a name");

    // Good names hold stored bytes or space padding, never NUL; checked on the first base byte of a file name.
    a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (res_reg.status == ST_FILE) |-> (res_reg.base_name[63:56] != 8'h00))
        else $error("file name holds a NUL byte");

endmodule

>>> src/path_component_to_short_name.sv
// Splits a NUL-terminated path, one byte per beat, into space-padded 8.3 names.
// Input channel: in_valid / in_ready with the path byte on ch.
// Output channel: out_valid / out_ready with status, base_name and extension.
// Each separator but one at the very start of a path, each dot after an extension
// and each NUL ends a component and gives one beat: a directory part, the final
// file name, an empty path or a length error. After a length error the bytes up
// to the next NUL give no beat. A byte is held in the input register, then parsed
// into the result register, from which its result leaves.
// Throughput: one byte per cycle while out_ready stays high, set by the
// combinational parse between the input register and the result register.
// When the receiver stalls, the result register holds its beat, the input
// register holds one more byte, and in_ready falls once both are full.
// Reset clears both registers and puts the parser at the start of a path.
module path_component_to_short_name (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [63:0] base_name,
    output logic [23:0] extension
);
    import pc2sn_pkg::*;

    logic       q_valid;
    logic [7:0] q_ch;
    logic       room;
    logic       go;
    logic       res_valid;
    res_t       res;

    // A held byte is parsed when the result register can take its result.
    assign go = q_valid && room;

    pc2sn_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ch       (ch),
        .take     (room),
        .q_valid  (q_valid),
        .q_ch     (q_ch)
    );

    pc2sn_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (q_ch),
        .go        (go),
        .res_valid (res_valid),
        .res       (res)
    );

    pc2sn_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .base_name (base_name),
        .extension (extension)
    );

endmodule
